/* src/cafilt_pkg.sv */
`timescale 1ns / 1ps

package cafilt_pkg;

  // identifier word flags and id masks
  localparam logic [31:0] F_EFF = 32'h8000_0000;
  localparam logic [31:0] F_RTR = 32'h4000_0000;
  localparam logic [31:0] F_ERR = 32'h2000_0000;
  localparam int unsigned SFF_IDS = 2048;
  localparam logic [31:0] M_SFF = 32'(SFF_IDS - 1);
  localparam logic [31:0] M_EFF = 32'h1FFF_FFFF;

  // highest interface number + 1 that a filter may name
  localparam int unsigned NUM_PORTS = 16;

  // results per receive beat at most
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned MCNT_W = $clog2(RESULT_LIMIT);

  // command codes
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_REG   = 2'd1;
  localparam logic [1:0] CMD_UNREG = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef enum logic [2:0] {
    CL_ERR = 3'd0,
    CL_ALL = 3'd1,
    CL_FIL = 3'd2,
    CL_INV = 3'd3,
    CL_EFF = 3'd4,
    CL_SFF = 3'd5
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_RX,
    OP_REG,
    OP_UNREG,
    OP_BADPORT
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REG,
    S_SCAN,
    S_FIN
  } state_t;

  // one stored filter
  typedef struct packed {
    cls_t        cls;
    logic [3:0]  port;
    logic [31:0] id;
    logic [31:0] mask;
    logic [7:0]  sub;
  } entry_t;

  // classified item between front and back
  typedef struct packed {
    op_t         op;
    cls_t        cls;
    logic [3:0]  port;
    logic [31:0] id;
    logic [31:0] mask;
    logic [7:0]  sub;
  } item_t;

endpackage

/* src/cafilt_ram.sv */
`timescale 1ns / 1ps

module cafilt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cafilt_front.sv */
`timescale 1ns / 1ps

module cafilt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [3:0]          port,
  input  logic [31:0]         can_id,
  input  logic [31:0]         mask,
  input  logic [7:0]          subscriber,
  output logic                q_push,
  output cafilt_pkg::item_t   q_item,
  input  logic                q_full
);

  logic               fr_valid;
  logic               fr_valid_next;
  cafilt_pkg::item_t  fr_item;
  cafilt_pkg::item_t  cls_item;
  logic               keep;
  logic               accept;
  logic [31:0]        m_norm;
  logic [31:0]        id_norm;
  cafilt_pkg::cls_t   cls;
  logic               bad_port;

  // filter normalisation
  always_comb begin
    m_norm  = '0;
    id_norm = can_id;
    cls     = cafilt_pkg::CL_FIL;
    if ((mask & cafilt_pkg::F_ERR) != '0) begin
      m_norm = mask & cafilt_pkg::M_EFF;
      cls    = cafilt_pkg::CL_ERR;
    end else begin
      if ((mask & cafilt_pkg::F_EFF) != '0) begin
        m_norm = mask & (cafilt_pkg::M_EFF | cafilt_pkg::F_EFF | cafilt_pkg::F_RTR);
      end else begin
        m_norm = mask & (cafilt_pkg::M_SFF | cafilt_pkg::F_RTR);
      end
      id_norm = can_id & m_norm;
      if ((can_id & cafilt_pkg::F_ERR) != '0) begin
        cls = cafilt_pkg::CL_INV;
      end else if (m_norm == '0) begin
        cls = cafilt_pkg::CL_ALL;
      end else if ((id_norm & cafilt_pkg::F_EFF) != '0) begin
        if (m_norm == (cafilt_pkg::M_EFF | cafilt_pkg::F_EFF)) begin
          cls = cafilt_pkg::CL_EFF;
        end
      end else if (m_norm == cafilt_pkg::M_SFF) begin
        cls = cafilt_pkg::CL_SFF;
      end
    end
  end

  assign bad_port = 9'(port) >= 9'(cafilt_pkg::NUM_PORTS);

  always_comb begin
    cls_item.cls  = cls;
    cls_item.port = port;
    cls_item.id   = id_norm;
    cls_item.mask = m_norm;
    cls_item.sub  = subscriber;
    cls_item.op   = cafilt_pkg::OP_RX;
    keep          = 1'b1;
    case (cmd)
      cafilt_pkg::CMD_RX: begin
        cls_item.id   = can_id;
        cls_item.mask = mask;
      end
      cafilt_pkg::CMD_REG: begin
        cls_item.op = bad_port ? cafilt_pkg::OP_BADPORT : cafilt_pkg::OP_REG;
      end
      cafilt_pkg::CMD_UNREG: begin
        cls_item.op = bad_port ? cafilt_pkg::OP_BADPORT : cafilt_pkg::OP_UNREG;
      end
      default: begin
        // unused command: taken and dropped
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = fr_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid && !q_full;
  assign q_item   = fr_item;

  always_comb begin
    fr_valid_next = fr_valid && !q_push;
    if (accept && keep) begin
      fr_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      fr_item <= cls_item;
    end
  end

endmodule

/* src/cafilt_queue.sv */
`timescale 1ns / 1ps

module cafilt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cafilt_pkg::item_t  push_item,
  output logic               full,
  output logic               head_valid,
  output cafilt_pkg::item_t  head_item,
  input  logic               pop
);

  cafilt_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full       = cnt == 2'd2;
  assign head_valid = cnt != 2'd0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/cafilt_back.sv */
`timescale 1ns / 1ps

module cafilt_back #(
  parameter int NUM_FILTERS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cafilt_pkg::item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         subscriber_out,
  output logic [4:0]         slot,
  output logic               last,
  output logic [5:0]         entries_in_use
);

  localparam int SW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int CW = $clog2(NUM_FILTERS + 1);
  localparam int EW = $bits(cafilt_pkg::entry_t);
  localparam int MW = cafilt_pkg::MCNT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_FILTERS - 1);
  localparam logic [MW-1:0] LAST_MATCH = MW'(cafilt_pkg::RESULT_LIMIT - 1);

  cafilt_pkg::state_t   state, state_next;
  logic [SW-1:0]        ptr, ptr_next;
  logic                 iss_done, iss_done_next;
  logic                 chk_valid, chk_valid_next;
  logic [SW-1:0]        chk_slot, chk_slot_next;
  logic                 pend_valid, pend_valid_next;
  cafilt_pkg::status_t  pend_status, pend_status_next;
  logic [7:0]           pend_sub, pend_sub_next;
  logic [SW-1:0]        pend_slot, pend_slot_next;
  logic [MW-1:0]        mcount, mcount_next;
  logic [NUM_FILTERS-1:0] valid, valid_next;
  logic [CW-1:0]        count, count_next;

  cafilt_pkg::status_t  o_status, o_status_next;
  logic [7:0]           o_sub, o_sub_next;
  logic [4:0]           o_slot, o_slot_next;
  logic                 o_last, o_last_next;
  logic [5:0]           o_count, o_count_next;
  logic                 out_valid_next;
  logic                 load_out;
  logic                 out_free;

  logic                 we;
  logic [SW-1:0]        raddr;
  logic [EW-1:0]        rdata;
  cafilt_pkg::entry_t   rd_entry;
  cafilt_pkg::entry_t   wr_entry;
  logic                 hit;
  logic                 stall;

  cafilt_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_FILTERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ptr),
    .wdata (EW'(wr_entry)),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_entry = cafilt_pkg::entry_t'(rdata);

  always_comb begin
    wr_entry.cls  = q_item.cls;
    wr_entry.port = q_item.port;
    wr_entry.id   = q_item.id;
    wr_entry.mask = q_item.mask;
    wr_entry.sub  = q_item.sub;
  end

  function automatic logic rx_match(cafilt_pkg::entry_t e, logic [31:0] f, logic [3:0] p);
    logic r;
    r = 1'b0;
    if (e.port == 4'd0 || e.port == p) begin
      if ((f & cafilt_pkg::F_ERR) != '0) begin
        r = (e.cls == cafilt_pkg::CL_ERR) && ((f & e.mask) != '0);
      end else begin
        case (e.cls)
          cafilt_pkg::CL_ALL: r = 1'b1;
          cafilt_pkg::CL_FIL: r = (f & e.mask) == e.id;
          cafilt_pkg::CL_INV: r = (f & e.mask) != e.id;
          cafilt_pkg::CL_EFF: r = ((f & cafilt_pkg::F_EFF) != '0) && (f == e.id);
          cafilt_pkg::CL_SFF: r = ((f & cafilt_pkg::F_EFF) == '0) &&
                                  ((f & cafilt_pkg::M_SFF) == e.id);
          default:            r = 1'b0;
        endcase
      end
    end
    return r;
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign hit = chk_valid && valid[chk_slot] &&
               ((q_item.op == cafilt_pkg::OP_RX) ? rx_match(rd_entry, q_item.id, q_item.port)
                                                 : (rd_entry == wr_entry));
  assign stall = (q_item.op == cafilt_pkg::OP_RX) && chk_valid && !out_free;

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    iss_done_next    = iss_done;
    chk_valid_next   = chk_valid;
    chk_slot_next    = chk_slot;
    pend_valid_next  = pend_valid;
    pend_status_next = pend_status;
    pend_sub_next    = pend_sub;
    pend_slot_next   = pend_slot;
    mcount_next      = mcount;
    valid_next       = valid;
    count_next       = count;
    o_status_next    = o_status;
    o_sub_next       = o_sub;
    o_slot_next      = o_slot;
    o_last_next      = o_last;
    o_count_next     = o_count;
    load_out         = 1'b0;
    q_pop            = 1'b0;
    we               = 1'b0;
    raddr            = chk_slot;

    case (state)
      cafilt_pkg::S_IDLE: begin
        if (q_valid) begin
          ptr_next        = '0;
          iss_done_next   = 1'b0;
          chk_valid_next  = 1'b0;
          pend_valid_next = 1'b0;
          mcount_next     = '0;
          case (q_item.op)
            cafilt_pkg::OP_RX,
            cafilt_pkg::OP_UNREG: state_next = cafilt_pkg::S_SCAN;
            cafilt_pkg::OP_REG:   state_next = cafilt_pkg::S_REG;
            default:              state_next = cafilt_pkg::S_FIN;
          endcase
        end
      end

      cafilt_pkg::S_REG: begin
        if (!valid[ptr]) begin
          we               = 1'b1;
          valid_next[ptr]  = 1'b1;
          count_next       = count + CW'(1);
          pend_valid_next  = 1'b1;
          pend_status_next = cafilt_pkg::ST_OK;
          pend_sub_next    = q_item.sub;
          pend_slot_next   = ptr;
          state_next       = cafilt_pkg::S_FIN;
        end else if (ptr == LAST_SLOT) begin
          state_next = cafilt_pkg::S_FIN;
        end else begin
          ptr_next = ptr + SW'(1);
        end
      end

      cafilt_pkg::S_SCAN: begin
        if (!stall) begin
          raddr = ptr;
          if (!iss_done) begin
            ptr_next      = (ptr == LAST_SLOT) ? ptr : ptr + SW'(1);
            iss_done_next = ptr == LAST_SLOT;
          end
          chk_valid_next = !iss_done;
          chk_slot_next  = ptr;
          if (chk_valid && chk_slot == LAST_SLOT) begin
            state_next = cafilt_pkg::S_FIN;
          end
          if (hit) begin
            pend_valid_next  = 1'b1;
            pend_status_next = cafilt_pkg::ST_OK;
            pend_slot_next   = chk_slot;
            if (q_item.op == cafilt_pkg::OP_RX) begin
              if (pend_valid) begin
                load_out      = 1'b1;
                o_status_next = pend_status;
                o_sub_next    = pend_sub;
                o_slot_next   = 5'(pend_slot);
                o_last_next   = 1'b0;
                o_count_next  = 6'(count);
              end
              pend_sub_next = rd_entry.sub;
              mcount_next   = mcount + MW'(1);
              if (mcount == LAST_MATCH) begin
                state_next = cafilt_pkg::S_FIN;
              end
            end else begin
              valid_next[chk_slot] = 1'b0;
              count_next           = count - CW'(1);
              pend_sub_next        = q_item.sub;
              state_next           = cafilt_pkg::S_FIN;
            end
          end
        end
      end

      cafilt_pkg::S_FIN: begin
        if (out_free) begin
          load_out     = 1'b1;
          q_pop        = 1'b1;
          o_last_next  = 1'b1;
          o_count_next = 6'(count);
          if (pend_valid) begin
            o_status_next = pend_status;
            o_sub_next    = pend_sub;
            o_slot_next   = 5'(pend_slot);
          end else begin
            o_sub_next  = q_item.sub;
            o_slot_next = '0;
            case (q_item.op)
              cafilt_pkg::OP_RX: begin
                o_status_next = cafilt_pkg::ST_NOMATCH;
                o_sub_next    = '0;
              end
              cafilt_pkg::OP_REG: o_status_next = cafilt_pkg::ST_FULL;
              default:            o_status_next = cafilt_pkg::ST_NOTFOUND;
            endcase
          end
          state_next = cafilt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = cafilt_pkg::S_IDLE;
      end
    endcase

    out_valid_next = load_out || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cafilt_pkg::S_IDLE;
      iss_done  <= 1'b0;
      chk_valid <= 1'b0;
      pend_valid <= 1'b0;
      mcount    <= '0;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state      <= state_next;
      iss_done   <= iss_done_next;
      chk_valid  <= chk_valid_next;
      pend_valid <= pend_valid_next;
      mcount     <= mcount_next;
      valid      <= valid_next;
      count      <= count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    chk_slot    <= chk_slot_next;
    pend_status <= pend_status_next;
    pend_sub    <= pend_sub_next;
    pend_slot   <= pend_slot_next;
    o_status    <= o_status_next;
    o_sub       <= o_sub_next;
    o_slot      <= o_slot_next;
    o_last      <= o_last_next;
    o_count     <= o_count_next;
  end

  assign status         = o_status;
  assign subscriber_out = o_sub;
  assign slot           = o_slot;
  assign last           = o_last;
  assign entries_in_use = o_count;

endmodule

/* src/can_id_acceptance_filter_table.sv */
`timescale 1ns / 1ps

// CAN identifier acceptance filter table. Each input beat is a receive (cmd 0),
// a register (cmd 1) or an unregister (cmd 2); cmd 3 is taken and dropped.
// Register scans up from slot 0 and stores the normalised filter in the
// lowest free slot. Unregister and receive walk the filter RAM one slot
// per cycle through its single read port; a receive also holds its scan
// for as long as a result beat waits on a stalled output. Every item
// gives one result beat, or one per match for a receive (up to
// RESULT_LIMIT; no match gives a single beat with status 1), the final
// beat marked by last. A front stage classifies beats into a two-deep
// queue, so input is taken while the back end scans. Filter storage
// needs no clearing pass after reset: the valid bits are flip-flops
// cleared by rst.
module can_id_acceptance_filter_table #(
  parameter int NUM_FILTERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  port,
  input  logic [31:0] can_id,
  input  logic [31:0] mask,
  input  logic [7:0]  subscriber,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  subscriber_out,
  output logic [4:0]  slot,
  output logic        last,
  output logic [5:0]  entries_in_use
);

  // classified beat from the front stage into the queue
  logic              q_push;
  logic              q_full;
  cafilt_pkg::item_t q_in_item;

  // queue head seen by the scan engine
  logic              q_valid;
  logic              q_pop;
  cafilt_pkg::item_t q_head;

  // front: command decode, port check and filter normalisation
  cafilt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .port       (port),
    .can_id     (can_id),
    .mask       (mask),
    .subscriber (subscriber),
    .q_push     (q_push),
    .q_item     (q_in_item),
    .q_full     (q_full)
  );

  // short decoupling queue
  cafilt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop)
  );

  // back: filter RAM, valid bits, slot scan and output register
  cafilt_back #(
    .NUM_FILTERS (NUM_FILTERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .subscriber_out (subscriber_out),
    .slot           (slot),
    .last           (last),
    .entries_in_use (entries_in_use)
  );

endmodule
